// ===== rtl/core/pess_pkg.sv =====
// Shared types and command codes for the periodic event slot scheduler.
package pess_pkg;
  localparam int CmdW = 3;
  localparam logic [CmdW-1:0] CMD_TICK   = 3'd0;
  localparam logic [CmdW-1:0] CMD_ADD    = 3'd1;
  localparam logic [CmdW-1:0] CMD_RESET  = 3'd2;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CmdW-1:0] CMD_ADJUST = 3'd4;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [31:0]     time_now;
    logic [31:0]     old_time;
    logic [31:0]     period_ticks;
    logic [15:0]     repeat_limit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] fired_mask;
    logic [7:0] finished_mask;
    logic [2:0] slot_index;
    logic       no_free_slot;
  } out_item_t;
endpackage

// ===== rtl/core/pess_stream_if.sv =====
// Valid/ready channel interfaces for input beats, result beats and configuration.
interface pess_in_if;
  import pess_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pess_out_if;
  import pess_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pess_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/periodic_event_slot_scheduler.sv =====
// Top level of the periodic event slot scheduler.
// Operation: a tick walks the slots one a cycle; a due slot with nonzero last time
//   and period stops the walk for a 32-step restoring divide (one quotient bit a
//   cycle), then a multiply-and-add state and an update state. Other commands
//   walk the slots one a cycle; the result is then held until it is taken.
// One item at a time; ready only while idle. Reset: rst_n synchronous active low.
module periodic_event_slot_scheduler #(
  parameter int NUM_SLOTS = 8
) (
  input logic clk,
  input logic rst_n,
  pess_in_if.sink    in_ch,
  pess_out_if.source out_ch,
  pess_cfg_if.sink   cfg_ch
);
  import pess_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = ($clog2(NUM_SLOTS + 1) > 3) ? $clog2(NUM_SLOTS + 1) : 3;
  localparam int MW = (NUM_SLOTS > 8) ? 8 : NUM_SLOTS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state_r;
  in_item_t    item_r;
  logic        one_fire_r;
  logic [CW-1:0] idx_r;
  logic [NUM_SLOTS-1:0] act_r;
  logic [31:0] per_r [NUM_SLOTS];
  logic [31:0] last_r [NUM_SLOTS];
  logic [15:0] lim_r [NUM_SLOTS];
  logic [15:0] cnt_r [NUM_SLOTS];
  logic [7:0]  fired_r, fin_r;
  logic [2:0]  sidx_r;
  logic        full_r, found_r, stop_r;
  // divider state: dividend shifts out, remainder builds up
  logic [31:0] dvd_r, dvs_r, quo_r;
  logic [31:0] rem_r;
  logic [5:0]  dcnt_r;
  logic [31:0] newlast_r;

  logic [SW-1:0] si;
  assign si = idx_r[SW-1:0];

  logic [31:0] cur_last, cur_per, due_diff, f_val;
  assign cur_last = last_r[si];
  assign cur_per  = per_r[si];
  assign due_diff = item_r.time_now - (cur_last + cur_per);
  assign f_val    = due_diff;

  logic [32:0] rem_sh, rem_sub;
  assign rem_sh  = {rem_r, dvd_r[31]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // Period count: small period n = quo+1; for period >= 2^31 the divide already
  // gives ceil((2^31 - f)/q), so n = quo. Only the low word of n*period matters.
  logic [31:0] mul_n, mul_lo;
  assign mul_n  = cur_per[31] ? quo_r : quo_r + 32'd1;
  assign mul_lo = mul_n * cur_per;

  logic [15:0] cnt_inc;
  assign cnt_inc = cnt_r[si] + 16'd1;

  logic [7:0] bit_sel;
  assign bit_sel = (idx_r < CW'(MW)) ? (8'd1 << idx_r[2:0]) : 8'd0;

  logic tick_hit;
  assign tick_hit = (item_r.cmd == CMD_TICK) && !stop_r && act_r[si] && !due_diff[31];

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = '{fired_mask: fired_r, finished_mask: fin_r,
                          slot_index: sidx_r, no_free_slot: full_r};

  logic last_slot;
  assign last_slot = (idx_r == CW'(NUM_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r <= '0;
      one_fire_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (cfg_ch.valid) one_fire_r <= cfg_ch.data;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            item_r <= in_ch.data;
            idx_r <= '0;
            fired_r <= '0; fin_r <= '0; sidx_r <= '0;
            full_r <= (in_ch.data.cmd == CMD_ADD);
            found_r <= 1'b0; stop_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // one slot per cycle; a firing slot holds the index until it is updated
          if (tick_hit) begin
            if (cur_last == 32'd0 || cur_per == 32'd0) begin
              newlast_r <= item_r.time_now;
              state_r <= S_UPD;
            end else begin
              if (!cur_per[31]) begin
                dvd_r <= f_val; dvs_r <= cur_per;
              end else begin
                dvd_r <= 32'h8000_0000 - f_val + (32'd0 - cur_per) - 32'd1;
                dvs_r <= 32'd0 - cur_per;
              end
              rem_r <= '0; quo_r <= '0; dcnt_r <= 6'd32;
              state_r <= S_DIV;
            end
          end else begin
            state_r <= last_slot ? S_OUT : S_SCAN;
            idx_r <= idx_r + CW'(1);
          end
          case (item_r.cmd)
            CMD_ADD: begin
              if (!found_r && !act_r[si]) begin
                found_r <= 1'b1; full_r <= 1'b0;
                act_r[si] <= 1'b1;
                per_r[si] <= item_r.period_ticks;
                lim_r[si] <= item_r.repeat_limit;
                last_r[si] <= item_r.time_now;
                cnt_r[si] <= '0;
                sidx_r <= idx_r[2:0];
              end
            end
            CMD_RESET: if (act_r[si]) last_r[si] <= item_r.time_now;
            CMD_CLEAR: act_r[si] <= 1'b0;
            CMD_ADJUST: begin
              if (act_r[si]) begin
                if (item_r.old_time == 32'd0 || cur_last == 32'd0)
                  last_r[si] <= item_r.time_now;
                else
                  last_r[si] <= cur_last + (item_r.time_now - item_r.old_time);
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (rem_sub[32]) begin
            rem_r <= rem_sh[31:0]; quo_r <= {quo_r[30:0], 1'b0};
          end else begin
            rem_r <= rem_sub[31:0]; quo_r <= {quo_r[30:0], 1'b1};
          end
          dvd_r <= {dvd_r[30:0], 1'b0};
          dcnt_r <= dcnt_r - 6'd1;
          if (dcnt_r == 6'd1) state_r <= S_MUL;
        end
        S_MUL: begin
          // last + n*per, modulo 2^32
          newlast_r <= cur_last + mul_lo;
          state_r <= S_UPD;
        end
        S_UPD: begin
          last_r[si] <= newlast_r;
          fired_r <= fired_r | bit_sel;
          if (lim_r[si] != 16'd0) begin
            cnt_r[si] <= cnt_inc;
            if (cnt_inc >= lim_r[si]) begin
              act_r[si] <= 1'b0;
              fin_r <= fin_r | bit_sel;
            end
          end
          if (one_fire_r) stop_r <= 1'b1;
          idx_r <= idx_r + CW'(1);
          state_r <= last_slot ? S_OUT : S_SCAN;
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r < CW'(NUM_SLOTS)) else $error("slot index overrun");
endmodule

// ===== sim/pess_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the slot scheduler: predicts each result beat and compares it.
module pess_checker (
  input  logic clk,
  input  logic rst_n,
  pess_in_if   in_ch,
  pess_out_if  out_ch,
  pess_cfg_if  cfg_ch,
  output int   errors,
  output int   pending,
  output int   beats_checked,
  output int   fires_seen
);
  import pess_pkg::*;

  localparam int Slots = 8;

  logic        act_q [Slots];
  logic [31:0] per_q [Slots];
  logic [31:0] last_q [Slots];
  logic [15:0] lim_q [Slots];
  logic [15:0] cnt_q [Slots];
  logic        single_fire;
  out_item_t   sched_results [$];

  function automatic logic is_due(logic [31:0] now, logic [31:0] last, logic [31:0] per);
    logic [31:0] d;
    d = now - (last + per);
    return !d[31];
  endfunction

  // Whole number of periods that moves the slot's next due time past now.
  function automatic logic [31:0] next_last(logic [31:0] now, logic [31:0] last,
                                            logic [31:0] per);
    logic [31:0] f;
    logic [63:0] n, q;
    if (per == 0) return now;
    f = now - last - per;
    if (!per[31]) n = {32'd0, f / per} + 64'd1;
    else begin
      q = 64'h1_0000_0000 - {32'd0, per};
      n = (64'h8000_0000 - {32'd0, f} + q - 64'd1) / q;
    end
    return 32'(({32'd0, last} + n * {32'd0, per}));
  endfunction

  task automatic apply_cmd(input in_item_t it, output out_item_t res);
    logic [31:0] diff;
    res = '0;
    case (it.cmd)
      CMD_TICK: begin
        for (int i = 0; i < Slots; i++) begin
          if (!act_q[i] || !is_due(it.time_now, last_q[i], per_q[i])) continue;
          last_q[i] = (last_q[i] == 0) ? it.time_now
                                       : next_last(it.time_now, last_q[i], per_q[i]);
          res.fired_mask[i] = 1'b1;
          if (lim_q[i] != 0) begin
            cnt_q[i] = cnt_q[i] + 16'd1;
            if (cnt_q[i] >= lim_q[i]) begin
              act_q[i] = 1'b0;
              res.finished_mask[i] = 1'b1;
            end
          end
          if (single_fire) break;
        end
      end
      CMD_ADD: begin
        res.no_free_slot = 1'b1;
        for (int i = 0; i < Slots; i++) begin
          if (!act_q[i]) begin
            act_q[i] = 1'b1;
            per_q[i] = it.period_ticks;
            lim_q[i] = it.repeat_limit;
            last_q[i] = it.time_now;
            cnt_q[i] = '0;
            res.slot_index = 3'(i);
            res.no_free_slot = 1'b0;
            break;
          end
        end
      end
      CMD_RESET: for (int i = 0; i < Slots; i++) if (act_q[i]) last_q[i] = it.time_now;
      CMD_CLEAR: for (int i = 0; i < Slots; i++) act_q[i] = 1'b0;
      CMD_ADJUST: begin
        diff = it.time_now - it.old_time;
        for (int i = 0; i < Slots; i++) begin
          if (!act_q[i]) continue;
          if (it.old_time == 0 || last_q[i] == 0) last_q[i] = it.time_now;
          else last_q[i] = last_q[i] + diff;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = sched_results.size();

  always @(posedge clk) begin
    out_item_t res, want;
    if (!rst_n) begin
      for (int i = 0; i < Slots; i++) begin
        act_q[i] = 1'b0;
        per_q[i] = '0; last_q[i] = '0; lim_q[i] = '0; cnt_q[i] = '0;
      end
      single_fire = 1'b0;
      sched_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) single_fire = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        apply_cmd(in_ch.data, res);
        sched_results.push_back(res);
      end
      if (out_ch.valid && out_ch.ready) begin
        beats_checked++;
        res = out_ch.data;
        if (res.fired_mask != 0) fires_seen++;
        if (sched_results.size() == 0) report("unexpected beat", 32'(res), 32'd0);
        else begin
          want = sched_results.pop_front();
          if (res.fired_mask != want.fired_mask)
            report("fired_mask", 32'(res.fired_mask), 32'(want.fired_mask));
          if (res.finished_mask != want.finished_mask)
            report("finished_mask", 32'(res.finished_mask), 32'(want.finished_mask));
          if (res.slot_index != want.slot_index)
            report("slot_index", 32'(res.slot_index), 32'(want.slot_index));
          if (res.no_free_slot != want.no_free_slot)
            report("no_free_slot", 32'(res.no_free_slot), 32'(want.no_free_slot));
        end
      end
    end
  end

  initial begin
    errors = 0;
    beats_checked = 0;
    fires_seen = 0;
  end
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Top of the slot scheduler bench: clock, reset, stimulus, receiver stalls, verdict.
module testbench;
  import pess_pkg::*;

  localparam int CycleLimit = 4_000_000;
  localparam int DrainWait  = 400;  // extra wait after the block drains, before the verdict

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   sent = 0;
  int   cfg_writes = 0;
  int   errors, pending, beats_checked, fires_seen;

  // sender burst state
  int          burst_left = 0;
  int          gap_max = 6;
  logic [31:0] clock_now = 0;

  pess_in_if  in_ch ();
  pess_out_if out_ch ();
  pess_cfg_if cfg_ch ();

  periodic_event_slot_scheduler dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  pess_checker scoreboard (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .pending(pending), .beats_checked(beats_checked),
    .fires_seen(fires_seen)
  );

  always #2 clk = ~clk;

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: switch stall mode every so often, and once hold ready low for a
  // long stretch so the block backs up and stalls its input.
  initial begin
    int mode, mode_left, hold_left;
    logic held;
    mode = 0; mode_left = 0; hold_left = 0; held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && beats_checked >= 400) begin
        held = 1'b1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 256);
        end
        mode_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one beat; hold valid across back-to-back beats inside a burst.
  task automatic send_beat(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    sent++;
  endtask

  // Drop valid and let the block drain before touching the register.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_cfg(input logic v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic in_item_t mk(logic [2:0] c, logic [31:0] t, logic [31:0] o,
                                  logic [31:0] p, logic [15:0] l);
    in_item_t it;
    it.cmd = c; it.time_now = t; it.old_time = o; it.period_ticks = p;
    it.repeat_limit = l;
    return it;
  endfunction

  // Mostly a sane timeline: time moves forward, adds use short periods and small
  // limits so slots fire, run out and get reused. The rest is wild noise.
  function automatic in_item_t random_beat();
    in_item_t it;
    int r;
    it = mk(CMD_TICK, 0, $urandom, $urandom, 16'($urandom));
    r = $urandom_range(0, 99);
    if (r < 45) begin
      clock_now = clock_now + $urandom_range(0, 40);
      it.time_now = clock_now;
    end else if (r < 65) begin
      it.cmd = CMD_ADD;
      it.time_now = clock_now;
      it.period_ticks = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30);
      it.repeat_limit = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 4));
    end else if (r < 70) begin
      it.cmd = CMD_RESET;
      it.time_now = clock_now;
    end else if (r < 73) begin
      it.cmd = CMD_CLEAR;
    end else if (r < 79) begin
      it.cmd = CMD_ADJUST;
      it.old_time = ($urandom_range(0, 3) == 0) ? 32'd0 : clock_now;
      clock_now = clock_now + $urandom_range(0, 500) - 250;
      it.time_now = clock_now;
    end else if (r < 90) begin
      clock_now = clock_now + $urandom_range(0, 2000);
      it.time_now = clock_now;
    end else begin
      it.cmd = 3'($urandom_range(0, 7));
      it.time_now = $urandom;
      if ($urandom_range(0, 1)) clock_now = it.time_now;
    end
    return it;
  endfunction

  initial begin
    in_item_t dir [$];
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill every slot with edge-case events, overflow, hit odd times.
    write_cfg(1'b0);
    dir.push_back(mk(CMD_TICK, 0, 0, 0, 0));
    dir.push_back(mk(CMD_ADD, 0, 0, 5, 0));                       // last time zero
    dir.push_back(mk(CMD_ADD, 10, 0, 0, 1));                      // period zero
    dir.push_back(mk(CMD_ADD, 10, 0, 32'h8000_0000, 16'hFFFF));
    dir.push_back(mk(CMD_ADD, 10, 0, 32'hFFFF_FFFF, 2));
    dir.push_back(mk(CMD_ADD, 20, 0, 3, 3));
    dir.push_back(mk(CMD_ADD, 20, 0, 7, 0));
    dir.push_back(mk(CMD_ADD, 20, 0, 1, 1));
    dir.push_back(mk(CMD_ADD, 20, 0, 100, 0));
    dir.push_back(mk(CMD_ADD, 30, 0, 9, 9));                      // table full
    dir.push_back(mk(CMD_TICK, 0, 0, 0, 0));                      // time zero
    dir.push_back(mk(CMD_TICK, 50, 0, 0, 0));
    dir.push_back(mk(CMD_TICK, 32'h7FFF_FFF0, 0, 0, 0));
    dir.push_back(mk(CMD_ADJUST, 60, 0, 0, 0));                   // old zero
    dir.push_back(mk(CMD_ADJUST, 1000, 60, 0, 0));
    dir.push_back(mk(CMD_RESET, 1000, 0, 0, 0));
    dir.push_back(mk(CMD_TICK, 2000, 0, 0, 0));
    dir.push_back(mk(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    dir.push_back(mk(3'd5, $urandom, $urandom, $urandom, 16'($urandom)));
    dir.push_back(mk(3'd6, $urandom, $urandom, $urandom, 16'($urandom)));
    dir.push_back(mk(3'd7, $urandom, $urandom, $urandom, 16'($urandom)));
    dir.push_back(mk(CMD_CLEAR, 0, 0, 0, 0));
    dir.push_back(mk(CMD_TICK, 5000, 0, 0, 0));
    foreach (dir[i]) send_beat(dir[i]);

    // Random phases alternating the single-fire setting; the middle one has
    // no sender gaps so it runs back to back.
    for (int ph = 0; ph < 3; ph++) begin
      wait_idle();
      write_cfg(ph != 1);
      gap_max = (ph == 1) ? 0 : 8;
      repeat (ph == 2 ? 600 : 700) send_beat(random_beat());
    end

    wait_idle();
    repeat (DrainWait) @(posedge clk);
    $display("sent %0d beats, checked %0d results (%0d with firings), %0d register writes",
             sent, beats_checked, fires_seen, cfg_writes);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
